// ----- hdl/rsc_pkg.sv -----
// Shared types and constants for the RPN stack calculator.
package rsc_pkg;

	localparam int WORD_W = 32;

	localparam logic [WORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] Q_MIN = 32'h8000_0000;

	typedef enum logic [3:0] {
		OP_PUSH     = 4'd0,
		OP_ADD      = 4'd1,
		OP_MUL      = 4'd2,
		OP_SUB      = 4'd3,
		OP_DIV      = 4'd4,
		OP_MOD      = 4'd5,
		OP_PEEK     = 4'd6,
		OP_DUP      = 4'd7,
		OP_SWAP     = 4'd8,
		OP_CLEAR    = 4'd9,
		OP_POP_SHOW = 4'd10
	} op_t;

	typedef struct packed {
		logic [3:0]               op;
		logic signed [WORD_W-1:0] number;
	} cmd_word_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     value_valid;
		logic                     underflow;
		logic                     overflow;
		logic                     divide_by_zero;
		logic                     swap_short;
		logic                     saturated;
		logic [7:0]               depth;
	} res_word_t;

endpackage

// ----- hdl/rsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/rsc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module rsc_div #(
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [31:0]   remainder
);

	import rsc_pkg::*;

	localparam int IW = $clog2(DW);

	logic          busy_q;
	logic          done_q;
	logic [IW-1:0] iter_q;
	logic [DW-1:0] quo_q;
	logic [31:0]   rem_q;
	logic [31:0]   dvs_q;
	logic [32:0]   trial;
	logic [32:0]   diff;
	logic          fits;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (iter_q == IW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[31:0] : trial[31:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- hdl/rpn_stack_calculator.sv -----
// Top level of the RPN stack calculator: sequencer, stack RAM and shared arithmetic.
//
// One command word is taken at a time; cmd_ready is high only while the
// sequencer is idle. Div and mod run on the restoring divider, which retires
// one quotient bit per cycle. Peek, dup and swap that find the stack too short,
// and a zero divisor (for mod, a zero integer part), skip the remaining steps.
// The stack lives in a single-port-write, single-port-read RAM with registered
// read data, so each pop is a registered read. A result word sits in an output
// register; the next command is taken while it waits, and the sequencer holds
// in its last step only if the previous result is still unclaimed. Stack
// entries are not cleared after reset and need no clearing pass: only entries
// below the fill count are ever read.
module rpn_stack_calculator #(
	parameter int DEPTH     = 128,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  rsc_pkg::cmd_word_t cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output rsc_pkg::res_word_t res
);

	import rsc_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int DW = WORD_W + FRAC_BITS;
	localparam int SW = 66;

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_DISPATCH = 14'b00000000000010,
		S_GETB     = 14'b00000000000100,
		S_GETA     = 14'b00000000001000,
		S_MUL      = 14'b00000000010000,
		S_DIV      = 14'b00000000100000,
		S_PUSH     = 14'b00000001000000,
		S_PEEK     = 14'b00000010000000,
		S_DUP      = 14'b00000100000000,
		S_SWAP1    = 14'b00001000000000,
		S_SWAP2    = 14'b00010000000000,
		S_SWAP3    = 14'b00100000000000,
		S_DONE     = 14'b01000000000000
	} state_t;

	state_t                   state_q;
	logic [3:0]               op_q;
	logic [CW-1:0]            cnt_q;
	logic                     from_mem_q;
	logic signed [WORD_W-1:0] val_q;
	logic signed [WORD_W-1:0] b_q;
	logic signed [WORD_W-1:0] shown_q;
	logic signed [63:0]       prod_q;
	logic                     neg_q;
	logic                     valid_q;
	logic                     under_q;
	logic                     over_q;
	logic                     dz_q;
	logic                     sshort_q;
	logic                     sat_q;
	res_word_t                res_q;
	logic                     res_valid_q;

	logic [CW-1:0]            cnt_m1;
	logic [CW-1:0]            cnt_m2;
	logic [CW+7:0]            cnt_ext;
	logic                     cnt_nz;
	logic                     cnt_ge2;
	logic                     cnt_full;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [WORD_W-1:0]        ram_wdata;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [WORD_W-1:0]        rd_data;

	logic signed [WORD_W-1:0] b_val;
	logic signed [WORD_W-1:0] a_val;
	logic [WORD_W-1:0]        b_val_mag;
	logic [WORD_W-1:0]        b_mag;
	logic [WORD_W-1:0]        a_mag;
	logic                     ib_zero;
	logic signed [63:0]       mul_full;

	logic                     div_start;
	logic [DW-1:0]            div_dividend;
	logic [WORD_W-1:0]        div_divisor;
	logic                     div_done;
	logic [DW-1:0]            div_quo;
	logic [WORD_W-1:0]        div_rem;

	logic signed [SW-1:0]     sat_in;
	logic signed [SW-1:0]     quo_s;
	logic signed [SW-1:0]     rem_s;
	logic                     clip_hit;
	logic [WORD_W-1:0]        clip_val;
	logic                     res_free;

	assign cnt_m1   = cnt_q - 1'b1;
	assign cnt_m2   = cnt_q - CW'(2);
	assign cnt_ext  = {8'b0, cnt_q};
	assign cnt_nz   = cnt_q != '0;
	assign cnt_ge2  = cnt_q > CW'(1);
	assign cnt_full = cnt_q == CW'(DEPTH);
	assign res_free = !res_valid_q || res_ready;

	assign b_val     = from_mem_q ? $signed(rd_data) : '0;
	assign a_val     = from_mem_q ? $signed(rd_data) : '0;
	assign b_val_mag = b_val[WORD_W-1] ? (~b_val + 1'b1) : b_val;
	assign b_mag     = b_q[WORD_W-1] ? (~b_q + 1'b1) : b_q;
	assign a_mag     = a_val[WORD_W-1] ? (~a_val + 1'b1) : a_val;
	assign ib_zero   = (b_val_mag >> FRAC_BITS) == '0;
	assign mul_full  = a_val * b_q;

	// divider operands: fixed-point quotient for div, integer parts for mod
	always_comb begin
		if (op_q == OP_MOD) begin
			div_dividend = DW'(a_mag >> FRAC_BITS);
			div_divisor  = b_mag >> FRAC_BITS;
		end else begin
			div_dividend = DW'(a_mag) << FRAC_BITS;
			div_divisor  = b_mag;
		end
		div_start = (state_q == S_GETA) && (op_q == OP_DIV || op_q == OP_MOD);
	end

	rsc_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// shared saturation to Q range
	always_comb begin
		quo_s = neg_q ? -SW'(div_quo) : SW'(div_quo);
		rem_s = (neg_q ? -SW'(div_rem) : SW'(div_rem)) <<< FRAC_BITS;
		sat_in = '0;
		unique case (state_q)
			S_GETA: begin
				sat_in = (op_q == OP_SUB) ? (SW'(a_val) - SW'(b_q)) : (SW'(a_val) + SW'(b_q));
			end
			S_MUL: begin
				sat_in = SW'(prod_q >>> FRAC_BITS);
			end
			S_DIV: begin
				sat_in = (op_q == OP_MOD) ? rem_s : quo_s;
			end
			default: begin
				sat_in = '0;
			end
		endcase
		clip_hit = !((&sat_in[SW-1:WORD_W-1]) || !(|sat_in[SW-1:WORD_W-1]));
		clip_val = clip_hit ? (sat_in[SW-1] ? Q_MIN : Q_MAX) : sat_in[WORD_W-1:0];
	end

	// stack RAM ports
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cnt_m1[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = val_q;
		unique case (state_q)
			S_DISPATCH: begin
				ram_re = cnt_nz;
			end
			S_GETB: begin
				ram_re = cnt_nz;
			end
			S_SWAP1: begin
				ram_re    = 1'b1;
				ram_raddr = cnt_m2[AW-1:0];
			end
			S_SWAP2: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_m1[AW-1:0];
				ram_wdata = rd_data;
			end
			S_SWAP3: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_m2[AW-1:0];
			end
			S_PUSH: begin
				ram_we = !cnt_full;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	rsc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					unique case (op_q)
						OP_PUSH: begin
							state_q <= S_PUSH;
						end
						OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_MOD, OP_POP_SHOW: begin
							if (cnt_nz) begin
								cnt_q <= cnt_m1;
							end
							state_q <= S_GETB;
						end
						OP_PEEK: begin
							state_q <= cnt_nz ? S_PEEK : S_DONE;
						end
						OP_DUP: begin
							state_q <= cnt_nz ? S_DUP : S_DONE;
						end
						OP_SWAP: begin
							state_q <= cnt_ge2 ? S_SWAP1 : S_DONE;
						end
						OP_CLEAR: begin
							cnt_q   <= '0;
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_GETB: begin
					if (op_q == OP_POP_SHOW) begin
						state_q <= S_DONE;
					end else if ((op_q == OP_DIV && b_val == '0) ||
							(op_q == OP_MOD && ib_zero)) begin
						state_q <= S_DONE;
					end else begin
						if (cnt_nz) begin
							cnt_q <= cnt_m1;
						end
						state_q <= S_GETA;
					end
				end
				S_GETA: begin
					if (op_q == OP_MUL) begin
						state_q <= S_MUL;
					end else if (op_q == OP_DIV || op_q == OP_MOD) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_MUL: begin
					state_q <= S_PUSH;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!cnt_full) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_PEEK: begin
					state_q <= S_DONE;
				end
				S_DUP: begin
					state_q <= S_PUSH;
				end
				S_SWAP1: begin
					state_q <= S_SWAP2;
				end
				S_SWAP2: begin
					state_q <= S_SWAP3;
				end
				S_SWAP3: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath and flags
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					op_q     <= cmd.op;
					val_q    <= cmd.number;
					shown_q  <= '0;
					valid_q  <= 1'b0;
					under_q  <= 1'b0;
					over_q   <= 1'b0;
					dz_q     <= 1'b0;
					sshort_q <= 1'b0;
					sat_q    <= 1'b0;
				end
			end
			S_DISPATCH: begin
				from_mem_q <= cnt_nz;
				if ((op_q == OP_ADD || op_q == OP_MUL || op_q == OP_SUB || op_q == OP_DIV ||
						op_q == OP_MOD || op_q == OP_POP_SHOW || op_q == OP_PEEK ||
						op_q == OP_DUP) && !cnt_nz) begin
					under_q <= 1'b1;
				end
				if (op_q == OP_SWAP && !cnt_ge2) begin
					sshort_q <= 1'b1;
				end
			end
			S_GETB: begin
				b_q        <= b_val;
				from_mem_q <= cnt_nz;
				if (op_q == OP_POP_SHOW) begin
					shown_q <= b_val;
					valid_q <= 1'b1;
				end else if ((op_q == OP_DIV && b_val == '0) ||
						(op_q == OP_MOD && ib_zero)) begin
					dz_q <= 1'b1;
				end else if (!cnt_nz) begin
					under_q <= 1'b1;
				end
			end
			S_GETA: begin
				prod_q <= mul_full;
				neg_q  <= (op_q == OP_MOD) ? a_val[WORD_W-1] : (a_val[WORD_W-1] ^ b_q[WORD_W-1]);
				if (op_q == OP_ADD || op_q == OP_SUB) begin
					val_q <= $signed(clip_val);
					if (clip_hit) begin
						sat_q <= 1'b1;
					end
				end
			end
			S_MUL: begin
				val_q <= $signed(clip_val);
				if (clip_hit) begin
					sat_q <= 1'b1;
				end
			end
			S_DIV: begin
				if (div_done) begin
					val_q <= $signed(clip_val);
					if (clip_hit) begin
						sat_q <= 1'b1;
					end
				end
			end
			S_PUSH: begin
				if (cnt_full) begin
					over_q <= 1'b1;
				end
			end
			S_PEEK: begin
				shown_q <= $signed(rd_data);
				valid_q <= 1'b1;
			end
			S_DUP: begin
				val_q <= $signed(rd_data);
			end
			S_SWAP1: begin
				val_q <= $signed(rd_data);
			end
			S_DONE: begin
				if (res_free) begin
					res_q.value          <= shown_q;
					res_q.value_valid    <= valid_q;
					res_q.underflow      <= under_q;
					res_q.overflow       <= over_q;
					res_q.divide_by_zero <= dz_q;
					res_q.swap_short     <= sshort_q;
					res_q.saturated      <= sat_q;
					res_q.depth          <= cnt_ext[7:0];
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	assign cmd_ready = state_q == S_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the RPN stack calculator: directed table, then random command words.
`timescale 1ns / 100ps

module testbench;
	import rsc_pkg::*;

	localparam int STACK_DEPTH = 128;
	localparam int FRAC_BITS = 16;
	localparam longint Q_ONE = longint'(1) << FRAC_BITS;
	localparam longint Q_MAX_L = longint'($signed(Q_MAX));
	localparam longint Q_MIN_L = longint'($signed(Q_MIN));
	localparam logic [3:0] OP_UNUSED_LO = 4'd11;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;
	localparam int RANDOM_WORDS = 1550;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 600000;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

	typedef struct packed {
		cmd_word_t cmd;
		logic      typed;
		res_word_t res;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_word_t cmd = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_word_t res;

	rpn_stack_calculator #(
		.DEPTH(STACK_DEPTH),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always #4 clk = ~clk;

	// calculator shadow state
	logic signed [31:0] calc_stack [0:STACK_DEPTH-1];
	int unsigned        calc_depth = 0;
	bit                 f_under, f_over, f_sat;

	res_word_t pending_res [$];
	dir_row_t  dir_rows [$];
	int        fail_count = 0;
	int        cycle_count = 0;
	int        burst_left = 0;
	int        rx_mode = 0;
	int        rx_phase_left = 0;

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > Q_MAX_L) begin
			f_sat = 1'b1;
			return Q_MAX;
		end
		if (v < Q_MIN_L) begin
			f_sat = 1'b1;
			return Q_MIN;
		end
		return v[31:0];
	endfunction

	function automatic void push_entry(input logic signed [31:0] v);
		if (calc_depth < STACK_DEPTH) begin
			calc_stack[calc_depth] = v;
			calc_depth++;
		end else begin
			f_over = 1'b1;
		end
	endfunction

	function automatic longint pop_entry();
		if (calc_depth > 0) begin
			calc_depth--;
			return calc_stack[calc_depth];
		end
		f_under = 1'b1;
		return 0;
	endfunction

	function automatic res_word_t rpn_eval(input cmd_word_t c);
		res_word_t          r;
		longint             a, b, ib;
		logic signed [31:0] t;
		r = '0;
		f_under = 1'b0;
		f_over = 1'b0;
		f_sat = 1'b0;
		case (c.op)
			OP_PUSH: push_entry(c.number);
			OP_ADD: begin
				b = pop_entry();
				a = pop_entry();
				push_entry(sat32(a + b));
			end
			OP_MUL: begin
				b = pop_entry();
				a = pop_entry();
				push_entry(sat32((a * b) >>> FRAC_BITS));
			end
			OP_SUB: begin
				b = pop_entry();
				a = pop_entry();
				push_entry(sat32(a - b));
			end
			OP_DIV: begin
				b = pop_entry();
				if (b == 0) begin
					r.divide_by_zero = 1'b1;
				end else begin
					a = pop_entry();
					push_entry(sat32((a <<< FRAC_BITS) / b));
				end
			end
			OP_MOD: begin
				b = pop_entry();
				ib = b / Q_ONE;
				if (ib == 0) begin
					r.divide_by_zero = 1'b1;
				end else begin
					a = pop_entry() / Q_ONE;
					push_entry(sat32((a % ib) * Q_ONE));
				end
			end
			OP_PEEK: begin
				if (calc_depth > 0) begin
					r.value = calc_stack[calc_depth-1];
					r.value_valid = 1'b1;
				end else begin
					f_under = 1'b1;
				end
			end
			OP_DUP: begin
				if (calc_depth > 0)
					push_entry(calc_stack[calc_depth-1]);
				else
					f_under = 1'b1;
			end
			OP_SWAP: begin
				if (calc_depth > 1) begin
					t = calc_stack[calc_depth-1];
					calc_stack[calc_depth-1] = calc_stack[calc_depth-2];
					calc_stack[calc_depth-2] = t;
				end else begin
					r.swap_short = 1'b1;
				end
			end
			OP_CLEAR: calc_depth = 0;
			OP_POP_SHOW: begin
				r.value = pop_entry();
				r.value_valid = 1'b1;
			end
			default: ;
		endcase
		r.underflow = f_under;
		r.overflow = f_over;
		r.saturated = f_sat;
		r.depth = 8'(calc_depth);
		return r;
	endfunction

	function automatic res_word_t res_of(input logic signed [31:0] v, input logic vv, un, ov,
			dz, ss, st, input logic [7:0] d);
		return {v, vv, un, ov, dz, ss, st, d};
	endfunction

	function automatic void add_row(input logic [3:0] op, input logic signed [31:0] n,
			input logic typed, input res_word_t r);
		dir_rows.push_back({op, n, typed, r});
	endfunction

	function automatic logic [3:0] rand_op(input mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				if (r < 90) return OP_PUSH;
				if (r < 94) return OP_DUP;
				return 4'($urandom_range(OP_ADD, OP_SWAP));
			end
			MIX_DRAIN: begin
				if (r < 30) return OP_PUSH;
				if (r < 32) return OP_CLEAR;
				if (r < 34) return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
				if (r < 60) return 4'($urandom_range(OP_ADD, OP_MOD));
				if (r < 80) return OP_POP_SHOW;
				return 4'($urandom_range(OP_PEEK, OP_SWAP));
			end
			default: begin
				if (r < 48) return OP_PUSH;
				if (r < 50) return OP_CLEAR;
				if (r < 53) return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
				if (r < 80) return 4'($urandom_range(OP_ADD, OP_MOD));
				if (r < 88) return OP_POP_SHOW;
				return 4'($urandom_range(OP_PEEK, OP_SWAP));
			end
		endcase
	endfunction

	function automatic logic signed [31:0] rand_number();
		int k;
		case ($urandom_range(0, 5))
			1: begin
				k = int'($urandom_range(0, 200)) - 100;
				return k <<< FRAC_BITS;
			end
			2: begin
				k = int'($urandom_range(0, 1 << 20)) - (1 << 19);
				return k;
			end
			3: begin
				case ($urandom_range(0, 6))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return 0;
					3: return 32'(Q_ONE);
					4: return 32'(-Q_ONE);
					5: return -1;
					default: return 1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic issue_word(input cmd_word_t w, input logic typed, input res_word_t typed_res);
		res_word_t predicted;
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		cmd <= w;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		predicted = rpn_eval(w);
		pending_res.push_back(typed ? typed_res : predicted);
		burst_left--;
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		if (rx_phase_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_phase_left <= $urandom_range(20, 300);
		end else begin
			rx_phase_left <= rx_phase_left - 1;
		end
		case (rx_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= 1'($urandom_range(0, 1));
			default: res_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin : check_results
		res_word_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_res.size() == 0) begin
				$error("result word with no expectation pending");
				fail_count++;
			end else begin
				want = pending_res.pop_front();
				if (res.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, res.value);
					fail_count++;
				end
				if (res.value_valid !== want.value_valid) begin
					$error("value_valid: expected %0b, got %0b", want.value_valid,
						res.value_valid);
					fail_count++;
				end
				if (res.underflow !== want.underflow) begin
					$error("underflow: expected %0b, got %0b", want.underflow, res.underflow);
					fail_count++;
				end
				if (res.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, res.overflow);
					fail_count++;
				end
				if (res.divide_by_zero !== want.divide_by_zero) begin
					$error("divide_by_zero: expected %0b, got %0b", want.divide_by_zero,
						res.divide_by_zero);
					fail_count++;
				end
				if (res.swap_short !== want.swap_short) begin
					$error("swap_short: expected %0b, got %0b", want.swap_short,
						res.swap_short);
					fail_count++;
				end
				if (res.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated, res.saturated);
					fail_count++;
				end
				if (res.depth !== want.depth) begin
					$error("depth: expected %0d, got %0d", want.depth, res.depth);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		cmd_word_t w;
		mix_t      mix;
		int        seg_left;
		mix = MIX_FILL;
		seg_left = $urandom_range(150, 250);

		// empty stack
		add_row(OP_POP_SHOW, 0, 1'b1, res_of(0, 1, 1, 0, 0, 0, 0, 0));
		add_row(OP_PEEK, 0, 1'b1, res_of(0, 0, 1, 0, 0, 0, 0, 0));
		add_row(OP_DUP, 0, 1'b1, res_of(0, 0, 1, 0, 0, 0, 0, 0));
		add_row(OP_SWAP, 0, 1'b1, res_of(0, 0, 0, 0, 0, 1, 0, 0));
		add_row(OP_ADD, 0, 1'b1, res_of(0, 0, 1, 0, 0, 0, 0, 1));
		add_row(OP_CLEAR, -1, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, 0));
		// saturation at both ends
		add_row(OP_PUSH, Q_MAX, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, 1));
		add_row(OP_PUSH, Q_MAX, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, 2));
		add_row(OP_ADD, 0, 1'b1, res_of(0, 0, 0, 0, 0, 0, 1, 1));
		add_row(OP_POP_SHOW, 0, 1'b1, res_of(Q_MAX, 1, 0, 0, 0, 0, 0, 0));
		add_row(OP_PUSH, Q_MIN, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, 1));
		add_row(OP_PUSH, 32'sh0001_0000, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, 2));
		add_row(OP_SUB, 0, 1'b1, res_of(0, 0, 0, 0, 0, 0, 1, 1));
		// zero divisors
		add_row(OP_PUSH, 0, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, 2));
		add_row(OP_DIV, 0, 1'b1, res_of(0, 0, 0, 0, 1, 0, 0, 1));
		add_row(OP_PUSH, 32'sh0000_8000, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, 2));
		add_row(OP_MOD, 0, 1'b1, res_of(0, 0, 0, 0, 1, 0, 0, 1));
		add_row(OP_PUSH, -32'sh0001_0000, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, 2));
		add_row(OP_DIV, 0, 1'b1, res_of(0, 0, 0, 0, 0, 0, 1, 1));
		add_row(OP_DUP, 0, 1'b0, '0);
		add_row(OP_MUL, 0, 1'b1, res_of(0, 0, 0, 0, 0, 0, 1, 1));
		add_row(OP_PUSH, -32'sh0007_0000, 1'b0, '0);
		add_row(OP_PUSH, 32'sh0003_0000, 1'b0, '0);
		add_row(OP_SWAP, 0, 1'b0, '0);
		add_row(OP_MOD, 0, 1'b0, '0);
		add_row(OP_PEEK, 0, 1'b0, '0);
		add_row(OP_UNUSED_HI, 32'sh5555_AAAA, 1'b0, '0);
		add_row(OP_POP_SHOW, 0, 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i])
			issue_word(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (seg_left == 0) begin
				mix = (mix == MIX_BALANCED) ? MIX_FILL : mix_t'(mix + 1);
				seg_left = $urandom_range(150, 250);
			end
			seg_left--;
			w.op = rand_op(mix);
			w.number = rand_number();
			issue_word(w, 1'b0, '0);
		end
		cmd_valid <= 1'b0;

		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
